### sv/soed_pkg.sv
`default_nettype none

package soed_pkg;

   localparam int SAMPLE_W = 12;
   localparam int THR_W    = 12;
   localparam int IDX_W    = 10;
   localparam int COUNT_W  = 10;

   localparam int SOED_WINDOW        = 5;
   localparam int SOED_MAX_POSITIONS = 1024;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_WIDTH = 1'd1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd90;
   localparam logic [IDX_W-1:0] MIN_WIDTH_RESET = 10'd5;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [THR_W-1:0]       threshold_type;
   typedef logic [IDX_W-1:0]       index_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   function automatic count_type count_inc(input count_type c);
      count_inc = (c == COUNT_MAX) ? COUNT_MAX : c + count_type'(1);
   endfunction

endpackage

`default_nettype wire

### sv/soed_req_if.sv
`default_nettype none

interface soed_req_if
   import soed_pkg::*;
   ;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

### sv/soed_rsp_if.sv
`default_nettype none

interface soed_rsp_if
   import soed_pkg::*;
   ;
   logic      valid;
   logic      ready;
   logic      object_closed;
   index_type start_index;
   index_type end_index;
   logic      inside_object;
   count_type object_count;
   logic      sweep_done;

   modport source (output valid, output object_closed, output start_index,
                   output end_index, output inside_object, output object_count,
                   output sweep_done, input ready);
   modport sink   (input valid, input object_closed, input start_index,
                   input end_index, input inside_object, input object_count,
                   input sweep_done, output ready);
endinterface

`default_nettype wire

### sv/scan_object_edge_detector.sv
// Edge detector for one sweep of IR samples, one item per sweep position.
// The first WINDOW items of a sweep fill the baseline window; each later
// item is compared with the floor average of the window: a rise above
// average + threshold opens an object, a fall below average - threshold
// closes it, and it counts when end - start exceeds min_width. Every item
// gives exactly one result; the item marked last reports the final count
// (an open object included) and clears the sweep state. Throughput is one
// item per clock while no result is stalled: the window sum is a running
// total and the average compare a constant multiply, so the state updates
// in the cycle an item is accepted. Each result is registered, shown in the
// cycle after its item, held while the next item is taken. Index saturates
// at MAX_POSITIONS - 1. The user writes threshold and min_width through the
// csr port only while the block is idle, which the block does not enforce.
`default_nettype none

module scan_object_edge_detector
   import soed_pkg::*;
#(
   parameter int WINDOW        = SOED_WINDOW,
   parameter int MAX_POSITIONS = SOED_MAX_POSITIONS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_wdata,
   soed_req_if.sink           req_ch,
   soed_rsp_if.source         rsp_ch
);

   localparam int POS_W  = $clog2(MAX_POSITIONS);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int X_W    = SAMPLE_W + 2;
   localparam int PROD_W = X_W + $clog2(WINDOW + 1);
   localparam int DIFF_W = (POS_W > IDX_W) ? POS_W : IDX_W;

   localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(MAX_POSITIONS - 1);
   localparam logic [POS_W:0]    POS_FILL  = (POS_W+1)'(WINDOW);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [PROD_W-1:0] WIN_MUL   = PROD_W'(WINDOW);

   threshold_type threshold_ff;
   index_type     min_width_ff;

   sample_type        window_ff [WINDOW];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              open_ff, open_in;
   logic [POS_W-1:0]  start_ff, start_in;
   count_type         count_ff, count_in;

   logic      rsp_valid_ff;
   logic      closed_ff, closed_in;
   index_type start_out_ff, start_out_in;
   index_type end_out_ff;
   logic      inside_ff, inside_in;
   count_type count_out_ff, count_out_in;
   logic      done_ff;

   logic              accept;
   logic              filled;
   logic [X_W-1:0]    lo_x;
   logic [X_W-1:0]    hi_x;
   logic              rise_cond, fall_cond;
   logic              rise, fall, open_mid;
   logic [POS_W-1:0]  start_mid;
   logic [DIFF_W-1:0] width;
   count_type         count_mid;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign filled = {1'b0, pos_ff} >= POS_FILL;

   // avg = floor(sum / WINDOW); compares are rewritten to avoid the divide
   assign lo_x = X_W'(req_ch.sample) + X_W'(threshold_ff) + X_W'(1);
   assign hi_x = X_W'(req_ch.sample) - X_W'(threshold_ff);

   assign rise_cond = (req_ch.sample > threshold_ff)
                      && (PROD_W'(sum_ff) < WIN_MUL * PROD_W'(hi_x));
   assign fall_cond = (WIN_MUL * PROD_W'(lo_x)) <= PROD_W'(sum_ff);

   always_comb begin
      rise      = filled && !open_ff && rise_cond;
      open_mid  = open_ff || rise;
      start_mid = rise ? pos_ff : start_ff;
      fall      = filled && open_mid && fall_cond;
      width     = DIFF_W'(pos_ff) - DIFF_W'(start_mid);
      closed_in = fall && (width > DIFF_W'(min_width_ff));
      count_mid = closed_in ? count_inc(count_ff) : count_ff;
      inside_in = open_mid && !fall;

      start_out_in = (fall || inside_in) ? index_type'(start_mid) : '0;
      count_out_in = (req_ch.last && inside_in) ? count_inc(count_mid) : count_mid;

      sum_in   = sum_ff - SUM_W'(window_ff[slot_ff]) + SUM_W'(req_ch.sample);
      open_in  = inside_in;
      start_in = start_mid;
      count_in = count_mid;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      if (pos_ff != POS_LAST) begin
         pos_in  = pos_ff + POS_W'(1);
         slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         min_width_ff <= MIN_WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff <= threshold_type'(csr_wdata);
            CSR_MIN_WIDTH: min_width_ff <= index_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // sweep state
   always_ff @(posedge clock) begin
      if (reset || (accept && req_ch.last)) begin
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff   <= '0;
         pos_ff   <= '0;
         slot_ff  <= '0;
         open_ff  <= 1'b0;
         start_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         window_ff[slot_ff] <= req_ch.sample;
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         open_ff  <= open_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         closed_ff    <= closed_in;
         start_out_ff <= start_out_in;
         end_out_ff   <= index_type'(pos_ff);
         inside_ff    <= inside_in;
         count_out_ff <= count_out_in;
         done_ff      <= req_ch.last;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.object_closed = closed_ff;
   assign rsp_ch.start_index   = start_out_ff;
   assign rsp_ch.end_index     = end_out_ff;
   assign rsp_ch.inside_object = inside_ff;
   assign rsp_ch.object_count  = count_out_ff;
   assign rsp_ch.sweep_done    = done_ff;

endmodule

`default_nettype wire

### sv/soed_checker.sv
`default_nettype none

module soed_checker
   import soed_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire logic      object_closed,
   input wire index_type start_index,
   input wire index_type end_index,
   input wire logic      inside_object,
   input wire count_type object_count,
   input wire logic      sweep_done
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(end_index)
         && $stable(object_count) && $stable(start_index) && $stable(sweep_done))
      else $error("result changed while stalled");

   // every accepted item shows a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   // a closed object is no longer open and has been counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && object_closed |-> !inside_object && (object_count != '0))
      else $error("closed object result inconsistent");

   // no result straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind scan_object_edge_detector soed_checker u_soed_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .object_closed (rsp_ch.object_closed),
   .start_index   (rsp_ch.start_index),
   .end_index     (rsp_ch.end_index),
   .inside_object (rsp_ch.inside_object),
   .object_count  (rsp_ch.object_count),
   .sweep_done    (rsp_ch.sweep_done)
);

`default_nettype wire

### sim/scan_object_edge_detector_test.sv
`default_nettype none

module scan_object_edge_detector_test;
   import soed_pkg::*;

   typedef struct {
      sample_type sample;
      logic       last;
      int         gap;
   } sweep_item_type;

   typedef struct {
      logic      object_closed;
      index_type start_index;
      index_type end_index;
      logic      inside_object;
      count_type object_count;
      logic      sweep_done;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   soed_req_if req_if();
   soed_rsp_if rsp_if();

   scan_object_edge_detector u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // detector state as seen from the item stream
   sample_type    win [SOED_WINDOW];
   logic [14:0]   win_sum;
   index_type     cur_pos;
   logic          in_obj;
   index_type     obj_start;
   count_type     obj_count;
   threshold_type thr_cfg;
   index_type     mw_cfg;

   sweep_item_type  sample_queue[$];
   scan_result_type results_due[$];

   logic req_fire;
   logic rsp_fire;
   int   stall_left;
   bit   stall_calm;
   int   errors;
   int   items_taken;
   int   results_seen;
   int   sweeps_seen;
   int   objects_seen;

   function automatic count_type bump(input count_type c);
      return (c == COUNT_MAX) ? c : c + count_type'(1);
   endfunction

   function automatic void clear_sweep();
      foreach (win[i]) win[i] = '0;
      win_sum   = '0;
      cur_pos   = '0;
      in_obj    = 1'b0;
      obj_start = '0;
      obj_count = '0;
   endfunction

   function automatic scan_result_type detect_edges(input sample_type s, input logic lst);
      scan_result_type r;
      int avg;
      int slot;
      r = '{default: '0};
      slot = int'(cur_pos) % SOED_WINDOW;
      r.end_index = cur_pos;
      if (int'(cur_pos) >= SOED_WINDOW) begin
         avg = int'(win_sum) / SOED_WINDOW;
         if (!in_obj && int'(s) > avg + int'(thr_cfg)) begin
            in_obj = 1'b1;
            obj_start = cur_pos;
         end
         if (in_obj && int'(s) + int'(thr_cfg) < avg) begin
            in_obj = 1'b0;
            r.start_index = obj_start;
            if (int'(cur_pos) - int'(obj_start) > int'(mw_cfg)) begin
               obj_count = bump(obj_count);
               r.object_closed = 1'b1;
            end
         end
      end
      win_sum = win_sum - win[slot] + s;
      win[slot] = s;
      r.inside_object = in_obj;
      if (in_obj) r.start_index = obj_start;
      r.object_count = obj_count;
      r.sweep_done = lst;
      if (lst) begin
         if (in_obj) r.object_count = bump(obj_count);
         clear_sweep();
      end else if (int'(cur_pos) < SOED_MAX_POSITIONS - 1) begin
         cur_pos = cur_pos + index_type'(1);
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // handshakes, prediction and result checking
   always @(posedge clock) begin
      scan_result_type exp_r;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         clear_sweep();
      end else begin
         req_fire <= req_if.valid && req_if.ready;
         rsp_fire <= rsp_if.valid && rsp_if.ready;
         if (req_if.valid && req_if.ready) begin
            results_due.push_back(detect_edges(req_if.sample, req_if.last));
            items_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               $error("result with no item outstanding");
               errors++;
            end else begin
               exp_r = results_due.pop_front();
               check_field("object_closed", exp_r.object_closed, rsp_if.object_closed);
               check_field("start_index", exp_r.start_index, rsp_if.start_index);
               check_field("end_index", exp_r.end_index, rsp_if.end_index);
               check_field("inside_object", exp_r.inside_object, rsp_if.inside_object);
               check_field("object_count", exp_r.object_count, rsp_if.object_count);
               check_field("sweep_done", exp_r.sweep_done, rsp_if.sweep_done);
               if (exp_r.sweep_done) sweeps_seen++;
               if (exp_r.object_closed) objects_seen++;
            end
         end
      end
   end

   // sample driver
   always @(negedge clock) begin
      sweep_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (sample_queue.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (sample_queue[0].gap != 0) begin
            sample_queue[0].gap = sample_queue[0].gap - 1;
            req_if.valid <= 1'b0;
         end else begin
            nxt = sample_queue.pop_front();
            req_if.valid  <= 1'b1;
            req_if.sample <= nxt.sample;
            req_if.last   <= nxt.last;
         end
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 49) == 0) stall_calm = !stall_calm;
            stall_left = stall_calm ? 0 : $urandom_range(0, 14);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic push_item(input sample_type s, input logic lst, input int gap);
      sweep_item_type it;
      it.sample = s;
      it.last   = lst;
      it.gap    = gap;
      sample_queue.push_back(it);
   endtask

   // flat baseline with noise, raised bumps as objects, some stray readings
   task automatic add_sweep(input int len);
      int base;
      int lift;
      int obj_left;
      int v;
      bit idle_mode;
      idle_mode = ($urandom_range(0, 3) != 0);
      if (int'(thr_cfg) > 3800) base = $urandom_range(0, 4095);
      else base = $urandom_range(0, 4094 - int'(thr_cfg));
      obj_left = 0;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            v = $urandom_range(0, 4095);
         end else begin
            if (obj_left == 0 && i >= SOED_WINDOW && $urandom_range(0, 5) == 0)
               obj_left = $urandom_range(1, 14);
            if (obj_left > 0) begin
               obj_left--;
               lift = int'(thr_cfg) + $urandom_range(1, 300);
            end else begin
               lift = 0;
            end
            v = base + lift + $urandom_range(0, 16) - 8;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
         end
         push_item(sample_type'(v), i == len - 1, idle_mode ? $urandom_range(0, 14) : 0);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input csr_data_type val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_THRESHOLD) thr_cfg = val;
      else mw_cfg = val[IDX_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_if.valid || results_due.size() != 0);
   endtask

   initial begin
      int t;
      int m;
      int target;
      int queued;
      int len;
      csr_we        = 1'b0;
      csr_index     = CSR_THRESHOLD;
      csr_wdata     = '0;
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      req_if.last   = 1'b0;
      rsp_if.ready  = 1'b0;
      thr_cfg       = THRESHOLD_RESET;
      mw_cfg        = MIN_WIDTH_RESET;
      errors        = 0;
      stall_calm    = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings
      push_item(12'd0, 1'b1, 0);                 // last during window fill
      repeat (5) push_item(12'd100, 1'b0, 0);
      repeat (7) push_item(12'hfff, 1'b0, 0);    // opens at first detect index
      push_item(12'd0, 1'b0, 0);                 // wide object closes
      push_item(12'hfff, 1'b0, 0);
      push_item(12'hfff, 1'b1, 0);               // open object counted on last
      repeat (5) push_item(12'd0, 1'b0, 0);
      push_item(12'd200, 1'b0, 0);
      push_item(12'd0, 1'b0, 0);                 // average below threshold, no close
      push_item(12'd0, 1'b1, 1);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         unique case (p)
            0: begin t = 0;    m = 0;    end
            1: begin t = 4095; m = 1023; end
            2: begin t = 60;   m = 0;    end
            3: begin t = 4095; m = 0;    end
            4: begin t = $urandom_range(1, 500);  m = $urandom_range(0, 12);   end
            5: begin t = $urandom_range(1, 2000); m = $urandom_range(0, 30);   end
            6: begin t = $urandom_range(0, 4095); m = $urandom_range(0, 1023); end
            default: begin t = 150; m = 3; end
         endcase
         write_reg(CSR_THRESHOLD, csr_data_type'(t));
         write_reg(CSR_MIN_WIDTH, csr_data_type'({2'($urandom_range(0, 3)), 10'(m)}));
         target = (p == 1 || p == 3) ? 40 : 100;
         if (p == 2) add_sweep(1040);            // runs the index into saturation
         queued = 0;
         while (queued < target) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 60);
            add_sweep(len);
            queued += len;
         end
         wait_idle();
      end

      repeat (4) @(posedge clock);
      if (results_due.size() != 0) begin
         $error("%0d results never arrived", results_due.size());
         errors++;
      end
      $display("%0d samples in %0d sweeps checked, %0d results compared, %0d objects closed",
               items_taken, sweeps_seen, results_seen, objects_seen);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
